@@ hdl/nfir_pkg.sv @@
// ----------------------------------------------------------------------------
// nfir_pkg
// Shared widths, register indexes and the per-cell step record for the
// normalized FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none
package nfir_pkg;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int KSUM_W   = 20;
  localparam int TAPS_W   = 3;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 3;
  // Sum of six 16x16 products fits in 35 bits.
  localparam int ACC_W    = 35;
  localparam int QUOT_W   = 35;
  localparam int CNT_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TAPS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KSUM = 3'd7;

  // Control carried from the sequencer to the tap cells.
  typedef struct packed {
    logic shift;   // accept a new sample into the chain
    logic mac;     // each cell registers its product with the tap weight
    logic pass;    // move partial sums one cell toward the output
  } cell_ctl_t;
endpackage
`default_nettype wire

@@ hdl/nfir_cell.sv @@
// ----------------------------------------------------------------------------
// nfir_cell
// One tap: holds one delay-line sample, forms its product with the tap
// weight, and adds it to the partial sum handed in from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module nfir_cell (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire nfir_pkg::cell_ctl_t                   ctl,
  input  wire logic                                  active,
  input  wire logic signed [nfir_pkg::SAMPLE_W-1:0]  smp_in,
  input  wire logic signed [nfir_pkg::COEF_W-1:0]    coef,
  input  wire logic signed [nfir_pkg::ACC_W-1:0]     sum_in,
  output logic signed [nfir_pkg::SAMPLE_W-1:0]       smp_out,
  output logic signed [nfir_pkg::ACC_W-1:0]          sum_out
);
  logic signed [nfir_pkg::SAMPLE_W-1:0] smp_r;
  logic signed [31:0]                   prod_r;
  logic signed [nfir_pkg::ACC_W-1:0]    sum_r;

  // Sample register of the delay line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
    end else if (ctl.shift) begin
      smp_r <= smp_in;
    end
  end

  // Registered product; unused taps contribute zero.
  always_ff @(posedge clk) begin
    if (ctl.mac) begin
      prod_r <= active ? smp_r * coef : 32'sd0;
    end
  end

  // Partial sum ripples one cell per pass cycle.
  always_ff @(posedge clk) begin
    if (ctl.pass) begin
      sum_r <= sum_in + nfir_pkg::ACC_W'(prod_r);
    end
  end

  assign smp_out = smp_r;
  assign sum_out = sum_r;
endmodule
`default_nettype wire

@@ hdl/nfir_div.sv @@
// ----------------------------------------------------------------------------
// nfir_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero, with 16-bit saturation of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module nfir_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [nfir_pkg::ACC_W-1:0]    dividend,
  input  wire logic signed [nfir_pkg::KSUM_W-1:0]   divisor,
  output logic                                      done,
  output logic signed [nfir_pkg::SAMPLE_W-1:0]      quot,
  output logic                                      clip
);
  localparam int W = nfir_pkg::QUOT_W;

  logic          busy_r;
  logic [5:0]    cnt_r;
  logic [W-1:0]  num_r;
  logic [W:0]    rem_r;
  logic [W-1:0]  den_r;
  logic          neg_r;
  logic [W:0]    trial;
  logic [W:0]    rem_sh;
  logic [W:0]    qmag;
  logic signed [W+1:0] qs;

  assign rem_sh = {rem_r[W-1:0], num_r[W-1]};
  assign trial  = rem_sh - {1'b0, den_r};

  // Iterate one bit per cycle; num_r collects quotient bits as it empties.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(W);
        num_r  <= dividend[W-1] ? W'(-dividend) : W'(dividend);
        den_r  <= divisor[nfir_pkg::KSUM_W-1] ? W'(-W'(divisor)) : W'(divisor);
        neg_r  <= dividend[W-1] ^ divisor[nfir_pkg::KSUM_W-1];
        rem_r  <= '0;
      end else if (busy_r) begin
        if (!trial[W]) begin
          rem_r <= trial;
          num_r <= {num_r[W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          num_r <= {num_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Sign and saturate the finished magnitude.
  always_comb begin
    qmag = {1'b0, num_r};
    qs   = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    clip = 1'b0;
    quot = qs[nfir_pkg::SAMPLE_W-1:0];
    if (qs > (W+2)'(32767)) begin
      quot = 16'sh7fff;
      clip = 1'b1;
    end else if (qs < -(W+2)'(32768)) begin
      quot = 16'sh8000;
      clip = 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ hdl/normalized_fir_filter.sv @@
// ----------------------------------------------------------------------------
// normalized_fir_filter
// Six-cell FIR chain normalized by a programmable kernel sum.
// A request passes through the product step, the sum passes toward cell 0,
// the divider start, the divider iterations and the output register; an
// invalid setup skips the divider and goes from the sum passes to output.
// One request at a time: the next request is taken once the result has been
// taken and the sequencer is idle again. Synchronous reset clears the delay line and
// loads the default coefficients.
// ----------------------------------------------------------------------------
`default_nettype none
module normalized_fir_filter #(
  parameter int MAX_TAPS = 6
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [nfir_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [nfir_pkg::SAMPLE_W-1:0]       out_filtered,
  output logic                                       out_clipped,
  output logic                                       out_invalid_setup,
  input  wire logic                                  cfg_we,
  input  wire logic [nfir_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [nfir_pkg::CFG_W-1:0]            cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_MAC, S_SUM, S_DIV, S_OUT} state_t;

  state_t state_r;
  logic [nfir_pkg::TAPS_W-1:0]              taps_r;
  logic signed [nfir_pkg::COEF_W-1:0]       coef_r [6];
  logic signed [nfir_pkg::KSUM_W-1:0]       ksum_r;
  logic [3:0]                               cnt_r;
  logic                                     inval_r;
  nfir_pkg::cell_ctl_t                      ctl;
  logic signed [nfir_pkg::SAMPLE_W-1:0]     smp [MAX_TAPS+1];
  logic signed [nfir_pkg::ACC_W-1:0]        sum [MAX_TAPS+1];
  logic [nfir_pkg::TAPS_W-1:0]              taps_eff;
  logic                                     div_start, div_done, div_clip;
  logic signed [nfir_pkg::SAMPLE_W-1:0]     div_q;
  logic                                     accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign taps_eff = (taps_r > nfir_pkg::TAPS_W'(MAX_TAPS)) ?
                    nfir_pkg::TAPS_W'(MAX_TAPS) : taps_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= 3'd1;
      ksum_r <= 20'sd4096;
      for (int i = 0; i < 6; i++) coef_r[i] <= (i == 0) ? 16'sd4096 : 16'sd0;
    end else if (cfg_we) begin
      if (cfg_index == nfir_pkg::REG_TAPS) begin
        taps_r <= cfg_data[nfir_pkg::TAPS_W-1:0];
      end else if (cfg_index == nfir_pkg::REG_KSUM) begin
        ksum_r <= cfg_data;
      end else begin
        coef_r[cfg_index - 3'd1] <= cfg_data[nfir_pkg::COEF_W-1:0];
      end
    end
  end

  // Tap cells: sample shifts toward higher index; sums ripple toward cell 0.
  assign smp[0] = in_sample;
  assign sum[MAX_TAPS] = '0;
  assign ctl.shift = accept;
  assign ctl.mac   = (state_r == S_MAC);
  assign ctl.pass  = (state_r == S_SUM) && (cnt_r != 4'd0);

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    nfir_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .active  (k < int'(taps_eff)),
      .smp_in  (smp[k]),
      .coef    (coef_r[k]),
      .sum_in  (sum[k+1]),
      .smp_out (smp[k+1]),
      .sum_out (sum[k])
    );
  end

  // The divider starts once every pass has reached cell 0.
  assign div_start = (state_r == S_SUM) && (cnt_r == 4'd0) && !inval_r;

  nfir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum[0]),
    .divisor  (ksum_r),
    .done     (div_done),
    .quot     (div_q),
    .clip     (div_clip)
  );

  // Sequencer with registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      cnt_r     <= '0;
      inval_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            inval_r <= (taps_r == '0) || (ksum_r == '0);
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          cnt_r   <= 4'(MAX_TAPS);
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (cnt_r == 4'd0) begin
            if (inval_r) begin
              out_filtered      <= '0;
              out_clipped       <= 1'b0;
              out_invalid_setup <= 1'b1;
              out_valid         <= 1'b1;
              state_r           <= S_OUT;
            end else begin
              state_r <= S_DIV;
            end
          end else begin
            cnt_r <= cnt_r - 4'd1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_filtered      <= div_q;
            out_clipped       <= div_clip;
            out_invalid_setup <= 1'b0;
            out_valid         <= 1'b1;
            state_r           <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result is only shown while the sequencer holds it.
  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("valid outside output state");
  // No new request while one is in flight.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !accept) else $error("accepted while busy");
  // An invalid setup never reports clipping and always shows a zero result.
  a_inval_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_setup |-> !out_clipped && out_filtered == '0)
    else $error("invalid setup result not zero");
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the normalized FIR filter with directed and random samples across
// several coefficient, tap count and kernel sum settings, predicts each
// result in a local model of the delay line and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS = 6;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [nfir_pkg::CFG_IDX_W-1:0] REG_COEF0 = 3'd1;

  typedef struct {
    logic signed [nfir_pkg::SAMPLE_W-1:0] filtered;
    logic                                 clipped;
    logic                                 invalid_setup;
  } fir_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [nfir_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [nfir_pkg::SAMPLE_W-1:0] out_filtered;
  logic out_clipped;
  logic out_invalid_setup;
  logic cfg_we = 1'b0;
  logic [nfir_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nfir_pkg::CFG_W-1:0] cfg_data = '0;

  // Shadow copy of the filter setup and the delay line.
  logic [nfir_pkg::TAPS_W-1:0]          taps_q;
  logic signed [nfir_pkg::COEF_W-1:0]   coef_q [NTAPS];
  logic signed [nfir_pkg::KSUM_W-1:0]   ksum_q;
  logic signed [nfir_pkg::SAMPLE_W-1:0] history_q [NTAPS];

  fir_result_t pending_results[$];
  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_receiver = 1'b0;
  longint cycle_count = 0;

  normalized_fir_filter uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample, .out_valid, .out_stall,
    .out_filtered, .out_clipped, .out_invalid_setup, .cfg_we, .cfg_index,
    .cfg_data
  );

  always #5 clk = ~clk;

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t", $realtime);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stall: random, or held high during a long hold-off.
  always @(posedge clk) begin
    if (hold_receiver) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    fir_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result filtered=%0d", $realtime, out_filtered);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_filtered !== exp_res.filtered) begin
          $display("%0t: filtered expected %0d actual %0d", $realtime,
                   exp_res.filtered, out_filtered);
          fail_count++;
        end
        if (out_clipped !== exp_res.clipped) begin
          $display("%0t: clipped expected %0b actual %0b", $realtime,
                   exp_res.clipped, out_clipped);
          fail_count++;
        end
        if (out_invalid_setup !== exp_res.invalid_setup) begin
          $display("%0t: invalid_setup expected %0b actual %0b", $realtime,
                   exp_res.invalid_setup, out_invalid_setup);
          fail_count++;
        end
      end
    end
  end

  // Shift the sample into the shadow delay line and compute the result.
  function automatic fir_result_t filter_sample(
    logic signed [nfir_pkg::SAMPLE_W-1:0] s);
    fir_result_t r;
    longint acc;
    longint quot;
    int taps;
    for (int k = NTAPS - 1; k > 0; k--) history_q[k] = history_q[k-1];
    history_q[0] = s;
    taps = (taps_q > NTAPS) ? NTAPS : taps_q;
    r.filtered = '0;
    r.clipped = 1'b0;
    r.invalid_setup = 1'b0;
    if (taps == 0 || ksum_q == 0) begin
      r.invalid_setup = 1'b1;
      return r;
    end
    acc = 0;
    for (int k = 0; k < taps; k++) begin
      acc += longint'(history_q[k]) * longint'(coef_q[k]);
    end
    quot = acc / longint'(ksum_q);
    if (quot > 32767) begin
      quot = 32767;
      r.clipped = 1'b1;
    end else if (quot < -32768) begin
      quot = -32768;
      r.clipped = 1'b1;
    end
    r.filtered = quot[nfir_pkg::SAMPLE_W-1:0];
    return r;
  endfunction

  // Register write; the shadow setup follows the same rules as the block.
  task automatic write_reg(logic [nfir_pkg::CFG_IDX_W-1:0] idx,
                           logic [nfir_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nfir_pkg::REG_TAPS) taps_q = val[nfir_pkg::TAPS_W-1:0];
    else if (idx == nfir_pkg::REG_KSUM) ksum_q = val[nfir_pkg::KSUM_W-1:0];
    else coef_q[idx - REG_COEF0] = val[nfir_pkg::COEF_W-1:0];
    @(posedge clk);
  endtask

  // Send one sample request, with a random idle gap before it.
  task automatic send_sample(logic signed [nfir_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(filter_sample(s));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every result, then let the block settle before a write.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [nfir_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return nfir_pkg::SAMPLE_W'(int'($urandom_range(15)) - 8);
      default: return nfir_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Load a full setup: taps, all six coefficients and the kernel sum.
  task automatic load_setup(int taps, bit rnd_coef, int ksum);
    logic signed [nfir_pkg::COEF_W-1:0] c;
    wait_idle();
    write_reg(nfir_pkg::REG_TAPS, nfir_pkg::CFG_W'(taps));
    for (int k = 0; k < NTAPS; k++) begin
      c = rnd_coef ? nfir_pkg::COEF_W'($urandom) : 16'sd4096;
      if (rnd_coef && $urandom_range(3) == 0) begin
        c = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
      write_reg(REG_COEF0 + nfir_pkg::CFG_IDX_W'(k),
                {{(nfir_pkg::CFG_W-nfir_pkg::COEF_W){c[nfir_pkg::COEF_W-1]}}, c});
    end
    write_reg(nfir_pkg::REG_KSUM, ksum[nfir_pkg::CFG_W-1:0]);
  endtask

  // Samples at the reset setup: identity filter, extremes of the sample.
  task automatic test_reset_setup();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
  endtask

  // Invalid setups, oversized tap count, saturation in both directions.
  task automatic test_special_cases();
    load_setup(0, 1'b0, 4096);
    send_sample(16'sd123);
    send_sample(16'sh8000);
    load_setup(3, 1'b0, 0);
    send_sample(16'sd77);
    load_setup(7, 1'b0, 4096);
    repeat (3) send_sample(16'sh7fff);
    repeat (3) send_sample(16'sh8000);
    load_setup(6, 1'b0, 1);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    load_setup(6, 1'b0, -524288);
    send_sample(16'sh7fff);
    load_setup(6, 1'b0, 524287);
    send_sample(16'sh8000);
    send_sample(-16'sd5);
  endtask

  // Random samples over a random setup at a given idling mix.
  task automatic test_random(int n, int idle_pct, int stall_pct);
    int ksum;
    case ($urandom_range(5))
      0: ksum = $urandom_range(3) - 1;
      1: ksum = $urandom_range(1) ? 524287 : -524288;
      default: ksum = int'($urandom_range(40000)) - 20000;
    endcase
    load_setup($urandom_range(7), 1'b1, ksum);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_sample(random_sample());
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Long receiver hold-off so the block backs up, then a full drain and more samples.
  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1'b1;
        repeat (600) @(posedge clk);
        hold_receiver = 1'b0;
      end
      repeat (20) send_sample(random_sample());
    join
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) send_sample(random_sample());
  endtask

  initial begin
    taps_q = 3'd1;
    ksum_q = 20'sd4096;
    for (int k = 0; k < NTAPS; k++) begin
      coef_q[k] = '0;
      history_q[k] = '0;
    end
    coef_q[0] = 16'sd4096;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_setup();
    test_special_cases();
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: test_random(56, 0, 0);
        1: test_random(56, 48, 0);
        2: test_random(56, 0, 48);
        default: test_random(56, 24, 24);
      endcase
    end
    test_backpressure();
    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
